// ===== rtl/assert_macros.svh =====
// Assertion macros for the alarm controller RTL.
// Included by acsc_core, the module that carries concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ACSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("acsc: property violated");

// The condition must never be true at a rising edge outside reset.
`define ACSC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("acsc: forbidden condition seen");

`endif

// ===== rtl/acsc_pkg.sv =====
// Shared types and constants of the alarm controller with snooze.
// Used by every module of the block; depends on nothing.
package acsc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SNOOZE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF   = 3'd5;

    // Reset values of the limit registers, in milliseconds.
    localparam logic [23:0] RING_LIMIT_RST   = 24'(30 * 60000);
    localparam logic [23:0] SNOOZE_LIMIT_RST = 24'(8 * 60000);
    localparam logic [9:0]  BLINK_HALF_RST   = 10'd500;

    // Weekday numbering: Sunday is 0, Monday to Friday are 1 to 5, Saturday is 6.
    localparam logic [2:0] DAY_SUNDAY      = 3'd0;
    localparam logic [2:0] DAY_MONDAY      = 3'd1;
    localparam logic [2:0] DAY_LAST_WORK   = 3'd5;
    localparam logic [2:0] DAY_SATURDAY    = 3'd6;

    // Alarm modes.
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_WEEKEND = 2'd1;
    localparam logic [1:0] MODE_WEEKDAY = 2'd2;
    localparam logic [1:0] MODE_DAILY   = 2'd3;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SNOOZE  = 2'd1,
        OP_DISMISS = 2'd2
    } t_op;

    // Settings held by the configuration register bank.
    typedef struct packed {
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic [1:0]  alarm_mode;
        logic [23:0] ring_limit_ms;
        logic [23:0] snooze_limit_ms;
        logic [9:0]  blink_half_ms;
    } t_cfg;

    // A write of the mode register, which also refreshes the dot.
    typedef struct packed {
        logic       we;
        logic [1:0] mode;
    } t_mode_wr;

    // One input item.
    typedef struct packed {
        logic [1:0] op;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [2:0] now_weekday;
        logic       clock_enabled;
    } t_item;

    // One result item.
    typedef struct packed {
        logic ringing;
        logic snoozing;
        logic dot_on;
        logic ring_began;
    } t_res;

endpackage

// ===== rtl/acsc_cfg.sv =====
// Configuration register bank of the alarm controller.
// Depends on acsc_pkg for the register indexes, reset values and types.
module acsc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output acsc_pkg::t_cfg                 o_cfg,
    output acsc_pkg::t_mode_wr             o_mode_wr
);

    acsc_pkg::t_cfg r_cfg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hour      <= 5'd0;
            r_cfg.alarm_minute    <= 6'd0;
            r_cfg.alarm_mode      <= acsc_pkg::MODE_OFF;
            r_cfg.ring_limit_ms   <= acsc_pkg::RING_LIMIT_RST;
            r_cfg.snooze_limit_ms <= acsc_pkg::SNOOZE_LIMIT_RST;
            r_cfg.blink_half_ms   <= acsc_pkg::BLINK_HALF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acsc_pkg::REG_ALARM_HOUR:   r_cfg.alarm_hour      <= i_cfg_data[4:0];
                acsc_pkg::REG_ALARM_MINUTE: r_cfg.alarm_minute    <= i_cfg_data[5:0];
                acsc_pkg::REG_ALARM_MODE:   r_cfg.alarm_mode      <= i_cfg_data[1:0];
                acsc_pkg::REG_RING_LIMIT:   r_cfg.ring_limit_ms   <= i_cfg_data[23:0];
                acsc_pkg::REG_SNOOZE_LIMIT: r_cfg.snooze_limit_ms <= i_cfg_data[23:0];
                acsc_pkg::REG_BLINK_HALF:   r_cfg.blink_half_ms   <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // A mode write is passed on so the core can refresh the dot at the same edge.
    assign o_mode_wr.we   = i_cfg_we && (i_cfg_index == acsc_pkg::REG_ALARM_MODE);
    assign o_mode_wr.mode = i_cfg_data[1:0];

endmodule

// ===== rtl/acsc_core.sv =====
// Alarm state and its single-pass update for one item.
// Depends on acsc_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module acsc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  acsc_pkg::t_item    i_item,
    input  acsc_pkg::t_cfg     i_cfg,
    input  acsc_pkg::t_mode_wr i_mode_wr,
    output acsc_pkg::t_res     o_res
);

    // Alarm state.
    logic        r_ring, r_snz, r_fired, r_dot;
    logic [5:0]  r_prev_min;
    logic [23:0] r_ring_el, r_snz_el;
    logic [10:0] r_blink_el;

    logic        n_ring, n_snz, n_fired, n_dot, n_began;
    logic [5:0]  n_prev_min;
    logic [23:0] n_ring_el, n_snz_el;
    logic [10:0] n_blink_el;

    logic        dot_ref, day_ok, is_wkday, is_wkend, match;

    assign dot_ref  = (i_cfg.alarm_mode != acsc_pkg::MODE_OFF);
    assign is_wkday = (i_item.now_weekday >= acsc_pkg::DAY_MONDAY) &&
                      (i_item.now_weekday <= acsc_pkg::DAY_LAST_WORK);
    assign is_wkend = (i_item.now_weekday == acsc_pkg::DAY_SUNDAY) ||
                      (i_item.now_weekday == acsc_pkg::DAY_SATURDAY);
    assign day_ok   = ((i_cfg.alarm_mode != acsc_pkg::MODE_WEEKDAY) || is_wkday) &&
                      ((i_cfg.alarm_mode != acsc_pkg::MODE_WEEKEND) || is_wkend);

    // Next state for the item in the input register, applied in order.
    always_comb begin
        n_ring     = r_ring;
        n_snz      = r_snz;
        n_fired    = r_fired;
        n_dot      = r_dot;
        n_prev_min = r_prev_min;
        n_ring_el  = r_ring_el;
        n_snz_el   = r_snz_el;
        n_blink_el = r_blink_el;
        n_began    = 1'b0;
        match      = 1'b0;
        case (acsc_pkg::t_op'(i_item.op))
            acsc_pkg::OP_TICK: begin
                // Elapsed counts saturate at all ones.
                if (r_ring_el != '1) n_ring_el = r_ring_el + 24'd1;
                if (r_snz_el != '1) n_snz_el = r_snz_el + 24'd1;
                if (r_blink_el != '1) n_blink_el = r_blink_el + 11'd1;
                if (i_item.now_minute != r_prev_min) n_fired = 1'b0;
                // Alarm time reached: fires once per matching minute.
                match = i_item.clock_enabled && !r_snz && dot_ref && !n_fired &&
                        (i_item.now_minute == i_cfg.alarm_minute) &&
                        (i_item.now_hour == i_cfg.alarm_hour) && day_ok;
                if (match) begin
                    n_fired = 1'b1;
                    if (!n_ring) begin
                        n_ring    = 1'b1;
                        n_snz     = 1'b0;
                        n_ring_el = '0;
                        n_dot     = dot_ref;
                        n_began   = 1'b1;
                    end
                end
                // Snooze over: ring again.
                if (n_snz && (n_snz_el > i_cfg.snooze_limit_ms) && !n_ring) begin
                    n_ring    = 1'b1;
                    n_snz     = 1'b0;
                    n_ring_el = '0;
                    n_dot     = dot_ref;
                    n_began   = 1'b1;
                end
                // Dot blink while snoozing.
                if (n_snz && (n_blink_el > {1'b0, i_cfg.blink_half_ms})) begin
                    n_dot      = !n_dot;
                    n_blink_el = '0;
                end
                // Ringing stops by itself after its limit.
                if (n_ring && (n_ring_el > i_cfg.ring_limit_ms)) begin
                    n_ring = 1'b0;
                    n_snz  = 1'b0;
                    n_dot  = dot_ref;
                end
                n_prev_min = i_item.now_minute;
            end
            acsc_pkg::OP_SNOOZE: begin
                if (r_ring && !r_snz) begin
                    n_ring   = 1'b0;
                    n_snz    = 1'b1;
                    n_snz_el = '0;
                    n_dot    = dot_ref;
                end
            end
            acsc_pkg::OP_DISMISS: begin
                if (r_ring || r_snz) begin
                    n_ring = 1'b0;
                    n_snz  = 1'b0;
                    n_dot  = dot_ref;
                end
            end
            default: begin
            end
        endcase
    end

    // State register; a mode write refreshes the dot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= 1'b0;
            r_snz      <= 1'b0;
            r_fired    <= 1'b0;
            r_dot      <= 1'b0;
            r_prev_min <= 6'd0;
            r_ring_el  <= 24'd0;
            r_snz_el   <= 24'd0;
            r_blink_el <= 11'd0;
        end else if (i_mode_wr.we) begin
            r_dot <= (i_mode_wr.mode != acsc_pkg::MODE_OFF);
        end else if (i_step) begin
            r_ring     <= n_ring;
            r_snz      <= n_snz;
            r_fired    <= n_fired;
            r_dot      <= n_dot;
            r_prev_min <= n_prev_min;
            r_ring_el  <= n_ring_el;
            r_snz_el   <= n_snz_el;
            r_blink_el <= n_blink_el;
        end
    end

    // Result reflects the state after the update.
    assign o_res.ringing    = n_ring;
    assign o_res.snoozing   = n_snz;
    assign o_res.dot_on     = n_dot;
    assign o_res.ring_began = n_began;

    // Ringing and snoozing exclude each other.
    `ACSC_NEVER(a_ring_snz_excl, i_clk, i_rst_n, r_ring && r_snz)
    // A start of ringing is never undone by the same item.
    `ACSC_ASSERT(a_began_rings, i_clk, i_rst_n, (i_step && n_began) |-> n_ring)
    // A dismiss leaves the alarm quiet.
    `ACSC_ASSERT(a_dismiss_quiet, i_clk, i_rst_n,
        (i_step && !i_mode_wr.we && (i_item.op == acsc_pkg::OP_DISMISS)) |=> (!r_ring && !r_snz))

endmodule

// ===== rtl/alarm_clock_snooze_controller_top.sv =====
// Top level of the alarm controller with snooze: stream ports, input and
// result registers. Depends on acsc_pkg, acsc_cfg and acsc_core.
//
// Usage: each input transfer on the s_axis channel is one operation (tick,
// snooze press or dismiss press, selected by s_axis_tuser); each produces
// exactly one result transfer on the m_axis channel with the alarm status
// after that operation. Settings are written through i_cfg_we, i_cfg_index
// and i_cfg_data while no item is in flight; writing the mode also sets the
// indicator dot.
// A result passes the input register and then the result register before it
// is offered on m_axis. Throughput: one item per cycle while the receiver
// takes each result; the state update is a single pass of compares and
// saturating 24-bit increments between the input register and the result
// register.
// Reset (i_rst_n low, synchronous) empties both registers, clears the alarm
// state and loads the default settings.
// When the receiver stalls, the result stays in the result register and one
// more item is held in the input register; s_axis_tready then drops until the
// result is taken.
module alarm_clock_snooze_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [4:0] now_hour, [10:5] now_minute, [13:11] now_weekday,
    // [14] clock_enabled, [15] zero.
    input  logic [15:0]                    s_axis_tdata,
    // [1:0] op.
    input  logic [1:0]                     s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] ringing, [1] snoozing, [2] dot_on, [3] ring_began, [7:4] zero.
    output logic [7:0]                     m_axis_tdata,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    acsc_pkg::t_cfg     cfg;
    acsc_pkg::t_mode_wr mode_wr;
    acsc_pkg::t_res     res;
    acsc_pkg::t_item    r_item;
    acsc_pkg::t_res     r_res;
    logic               r_in_valid, r_out_valid;
    logic               in_xfer, step;

    // The item moves on when the result register is free or being emptied.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.op            <= s_axis_tuser;
            r_item.now_hour      <= s_axis_tdata[4:0];
            r_item.now_minute    <= s_axis_tdata[10:5];
            r_item.now_weekday   <= s_axis_tdata[13:11];
            r_item.clock_enabled <= s_axis_tdata[14];
        end
    end

    acsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_mode_wr   (mode_wr)
    );

    acsc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .i_mode_wr (mode_wr),
        .o_res     (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_res.ring_began, r_res.dot_on, r_res.snoozing,
                            r_res.ringing};

endmodule
